### rtl/core/obb_pkg.sv
// Package with widths and helper functions for the oriented box overlap test.
`default_nettype none
package obb_pkg;
   localparam int CompWidth = 16;
   localparam int FracBits = 14;
   localparam longint ParallelLimit = 16383;
   // Axis dot products: 16x16 products summed over three terms.
   localparam int CosWidth = 2 * CompWidth + 2;
   // Magnitude of a cosine, unsigned.
   localparam int MagWidth = CosWidth - 1;
   // Half length times cosine magnitude.
   localparam int HalfProdWidth = CompWidth + MagWidth;
   // Center offset is one bit wider than a component.
   localparam int DiffWidth = CompWidth + 1;
   // Offset projection on one axis.
   localparam int ProjWidth = CompWidth + DiffWidth + 2;
   // Comparison width: a projection times a cosine, which bounds every side
   // of every test.
   localparam int WideWidth = ProjWidth + CosWidth;
   localparam logic [CosWidth-1:0] CosLimit = CosWidth'(ParallelLimit <<< FracBits);

   typedef logic signed [CompWidth-1:0] comp_type;
   typedef logic signed [CosWidth-1:0] cos_type;
   typedef logic [MagWidth-1:0] mag_type;
   typedef logic [HalfProdWidth-1:0] hprod_type;
   typedef logic signed [ProjWidth-1:0] proj_type;
   typedef logic signed [DiffWidth-1:0] diff_type;
   typedef logic signed [WideWidth-1:0] wide_type;

   function automatic comp_type comp_s(input logic [3*CompWidth-1:0] w, input int k);
      return comp_type'(w[k*CompWidth +: CompWidth]);
   endfunction

   function automatic wide_type half_w(input logic [3*CompWidth-1:0] w, input int k);
      return wide_type'({1'b0, w[k*CompWidth +: CompWidth]});
   endfunction

   // Unsigned half length times a cosine magnitude.
   function automatic hprod_type half_mul(input logic [3*CompWidth-1:0] w, input int k,
                                          input mag_type m);
      return hprod_type'(w[k*CompWidth +: CompWidth]) * hprod_type'(m);
   endfunction

   // Signed projection times a signed cosine.
   function automatic wide_type edge_mul(input proj_type t, input cos_type c);
      return wide_type'(t) * wide_type'(c);
   endfunction
endpackage
`default_nettype wire

### rtl/core/oriented_box_overlap_test.sv
// Top level of the pipelined oriented box overlap test.
`default_nettype none
// Oriented box overlap test by the separating axis method. A box pair is
// transferred at a rising edge with start high and busy low; busy is high
// only while reset is held, so outside reset one pair is taken every clock
// cycle. The pipeline has three register stages (cosines and projections,
// test sides, comparison), so rsp_valid pulses with rsp_overlap after the
// last stage, one result per transfer, in order. The receiver cannot stall the
// result. overlap is 1 when none of the fifteen axes separates the boxes;
// edge axes are skipped when an axis pair is nearly parallel. Touching
// boxes count as overlapping.
module oriented_box_overlap_test (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [47:0] req_a_center,
   input  wire logic [47:0] req_a_axis_x,
   input  wire logic [47:0] req_a_axis_y,
   input  wire logic [47:0] req_a_axis_z,
   input  wire logic [47:0] req_a_half,
   input  wire logic [47:0] req_b_center,
   input  wire logic [47:0] req_b_axis_x,
   input  wire logic [47:0] req_b_axis_y,
   input  wire logic [47:0] req_b_axis_z,
   input  wire logic [47:0] req_b_half,
   output logic             rsp_valid,
   output logic             rsp_overlap
);
   obb_pkg::cos_type  cos [9];
   obb_pkg::proj_type ta [3];
   obb_pkg::proj_type tb [3];
   logic [47:0] ha, hb;
   logic par1, par2_ff;
   obb_pkg::wide_type lhs [15];
   obb_pkg::wide_type rhs [15];
   logic [1:0] vld_ff;
   logic overlap_in, overlap_ff, valid_ff;

   // No pair is taken while reset is held.
   assign busy = reset;

   obb_cos u_cos (
      .clock (clock),
      .boxes ({req_b_half, req_b_axis_z, req_b_axis_y, req_b_axis_x, req_b_center,
               req_a_half, req_a_axis_z, req_a_axis_y, req_a_axis_x, req_a_center}),
      .cos_ff (cos), .ta_ff (ta), .tb_ff (tb), .ha_ff (ha), .hb_ff (hb),
      .par_ff (par1)
   );

   obb_sides u_sides (
      .clock (clock), .cos (cos), .ta (ta), .tb (tb), .ha (ha), .hb (hb),
      .lhs_ff (lhs), .rhs_ff (rhs)
   );

   // Final stage: any face test or, without a parallel pair, any edge test
   // with a strictly larger distance separates the boxes.
   always_comb begin
      overlap_in = 1'b1;
      for (int n = 0; n < 15; n++) begin
         if ((n < 6 || !par2_ff) && lhs[n] > rhs[n])
            overlap_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      par2_ff    <= par1;
      overlap_ff <= overlap_in;
      if (reset) begin
         vld_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         vld_ff   <= {vld_ff[0], start};
         valid_ff <= vld_ff[1];
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_overlap = overlap_ff;
endmodule
`default_nettype wire

### rtl/core/obb_cos.sv
// First stage: axis cosines, offset projections and the parallel flag.
`default_nettype none
module obb_cos (
   input  wire logic                            clock,
   input  wire logic [10*3*obb_pkg::CompWidth-1:0] boxes,
   output obb_pkg::cos_type                     cos_ff  [9],
   output obb_pkg::proj_type                    ta_ff   [3],
   output obb_pkg::proj_type                    tb_ff   [3],
   output logic [3*obb_pkg::CompWidth-1:0]      ha_ff,
   output logic [3*obb_pkg::CompWidth-1:0]      hb_ff,
   output logic                                 par_ff
);
   localparam int W = 3 * obb_pkg::CompWidth;
   obb_pkg::cos_type  cos_in [9];
   obb_pkg::proj_type ta_in [3];
   obb_pkg::proj_type tb_in [3];
   logic par_in;

   always_comb begin
      obb_pkg::diff_type d [3];
      logic [W-1:0] aw [3];
      logic [W-1:0] bw [3];
      for (int i = 0; i < 3; i++) begin
         aw[i] = boxes[(1 + i) * W +: W];
         bw[i] = boxes[(6 + i) * W +: W];
      end
      for (int k = 0; k < 3; k++) begin
         d[k] = obb_pkg::diff_type'(obb_pkg::comp_s(boxes[5*W +: W], k))
              - obb_pkg::diff_type'(obb_pkg::comp_s(boxes[0 +: W], k));
      end
      par_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cos_in[3*i+j] = '0;
            for (int k = 0; k < 3; k++) begin
               cos_in[3*i+j] += obb_pkg::cos_type'(obb_pkg::comp_s(aw[i], k))
                                * obb_pkg::cos_type'(obb_pkg::comp_s(bw[j], k));
            end
            if (cos_in[3*i+j] > $signed({1'b0, obb_pkg::CosLimit[obb_pkg::CosWidth-2:0]}) ||
                -cos_in[3*i+j] > $signed({1'b0, obb_pkg::CosLimit[obb_pkg::CosWidth-2:0]}))
               par_in = 1'b1;
         end
         ta_in[i] = '0;
         tb_in[i] = '0;
         for (int k = 0; k < 3; k++) begin
            ta_in[i] += obb_pkg::proj_type'(obb_pkg::comp_s(aw[i], k))
                        * obb_pkg::proj_type'(d[k]);
            tb_in[i] += obb_pkg::proj_type'(obb_pkg::comp_s(bw[i], k))
                        * obb_pkg::proj_type'(d[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      ta_ff  <= ta_in;
      tb_ff  <= tb_in;
      ha_ff  <= boxes[4*W +: W];
      hb_ff  <= boxes[9*W +: W];
      par_ff <= par_in;
   end
endmodule
`default_nettype wire

### rtl/core/obb_sides.sv
// Second stage: both sides of all fifteen separating axis tests.
`default_nettype none
module obb_sides (
   input  wire logic                        clock,
   input  wire obb_pkg::cos_type            cos   [9],
   input  wire obb_pkg::proj_type           ta    [3],
   input  wire obb_pkg::proj_type           tb    [3],
   input  wire logic [3*obb_pkg::CompWidth-1:0] ha,
   input  wire logic [3*obb_pkg::CompWidth-1:0] hb,
   output obb_pkg::wide_type                lhs_ff [15],
   output obb_pkg::wide_type                rhs_ff [15]
);
   localparam int F = obb_pkg::FracBits;
   obb_pkg::wide_type lhs_in [15];
   obb_pkg::wide_type rhs_in [15];

   always_comb begin
      obb_pkg::mag_type  ac [3][3];
      obb_pkg::wide_type t [3];
      obb_pkg::wide_type u [3];
      obb_pkg::wide_type e;
      obb_pkg::wide_type s;
      for (int i = 0; i < 3; i++) begin
         t[i] = obb_pkg::wide_type'(ta[i]);
         u[i] = obb_pkg::wide_type'(tb[i]);
         for (int j = 0; j < 3; j++) begin
            ac[i][j] = obb_pkg::mag_type'(cos[3*i+j] < 0 ? -cos[3*i+j] : cos[3*i+j]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         lhs_in[i] = (t[i] < 0 ? -t[i] : t[i]) <<< F;
         rhs_in[i] = obb_pkg::half_w(ha, i) <<< (2 * F);
         lhs_in[3+i] = (u[i] < 0 ? -u[i] : u[i]) <<< F;
         rhs_in[3+i] = obb_pkg::half_w(hb, i) <<< (2 * F);
         for (int k = 0; k < 3; k++) begin
            rhs_in[i]   += obb_pkg::wide_type'(obb_pkg::half_mul(hb, k, ac[i][k]));
            rhs_in[3+i] += obb_pkg::wide_type'(obb_pkg::half_mul(ha, k, ac[k][i]));
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            e = obb_pkg::edge_mul(ta[(i+2)%3], cos[3*((i+1)%3)+j])
              - obb_pkg::edge_mul(ta[(i+1)%3], cos[3*((i+2)%3)+j]);
            lhs_in[6+3*i+j] = e < 0 ? -e : e;
            s = obb_pkg::wide_type'(obb_pkg::half_mul(ha, (i+1)%3, ac[(i+2)%3][j]))
              + obb_pkg::wide_type'(obb_pkg::half_mul(ha, (i+2)%3, ac[(i+1)%3][j]))
              + obb_pkg::wide_type'(obb_pkg::half_mul(hb, (j+1)%3, ac[i][(j+2)%3]))
              + obb_pkg::wide_type'(obb_pkg::half_mul(hb, (j+2)%3, ac[i][(j+1)%3]));
            rhs_in[6+3*i+j] = s <<< F;
         end
      end
   end

   always_ff @(posedge clock) begin
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
   end
endmodule
`default_nettype wire

### rtl/core/obb_checker.sv
// Port level checker for the oriented box overlap test, with its bind.
`default_nettype none
module obb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);
   a_lat: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_valid) else $error("result missing");
   a_none: assert property (@(posedge clock) disable iff (reset)
      !start ##1 !start ##1 !start |=> !rsp_valid) else $error("result invented");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      !busy) else $error("busy raised");
endmodule

bind oriented_box_overlap_test obb_checker u_obb_checker (
   .clock (clock), .reset (reset), .start (start), .busy (busy),
   .rsp_valid (rsp_valid)
);
`default_nettype wire

### test/tb_oriented_box_overlap_test.sv
// Self-checking testbench for the pipelined oriented box overlap test.
`default_nettype none
module tb_oriented_box_overlap_test;
   // One box pair as the ten packed 48-bit request words, in port order:
   // a_center, a_axis_x/y/z, a_half, b_center, b_axis_x/y/z, b_half.
   // hold_off is the number of idle cycles the sender waits before offering
   // the pair, and wait_drain makes it wait until no result is outstanding.
   typedef struct {
      logic [9:0][47:0] words;
      int               hold_off;
      bit               wait_drain;
   } box_pair_type;

   // Full width for the predicted test sides.
   typedef logic signed [127:0] ref_wide_type;

   localparam int WatchdogLimit = 2000;
   localparam int RandomPairs = 1400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic rsp_valid;
   logic rsp_overlap;
   logic [9:0][47:0] drive_words = '0;

   box_pair_type pair_queue[$];
   bit overlap_queue[$];
   int failures = 0;
   int idle_cycles = 0;
   int stall_count = 0;
   bit pair_taken = 1'b0;

   oriented_box_overlap_test DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_a_center (drive_words[0]),
      .req_a_axis_x (drive_words[1]),
      .req_a_axis_y (drive_words[2]),
      .req_a_axis_z (drive_words[3]),
      .req_a_half   (drive_words[4]),
      .req_b_center (drive_words[5]),
      .req_b_axis_x (drive_words[6]),
      .req_b_axis_y (drive_words[7]),
      .req_b_axis_z (drive_words[8]),
      .req_b_half   (drive_words[9]),
      .rsp_valid    (rsp_valid),
      .rsp_overlap  (rsp_overlap)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint comp_at(input logic [47:0] w, input int k);
      return longint'($signed(w[k*obb_pkg::CompWidth +: obb_pkg::CompWidth]));
   endfunction

   function automatic ref_wide_type wide_abs(input ref_wide_type x);
      return (x < 0) ? -x : x;
   endfunction

   // Separating axis test at full width. Cosines carry scale 2^(2F), the
   // projected offsets 2^(F+4) and the half lengths 2^4, so each side is
   // shifted to a common exponent before the strict comparison.
   function automatic bit boxes_touch(input logic [9:0][47:0] w);
      longint ax[3][3], bx[3][3], ha[3], hb[3], d[3];
      longint c[3][3], ac[3][3], t[3], u;
      ref_wide_type lhs, rhs;
      bit nearly_parallel;
      int i, j, k, i1, i2, j1, j2;
      nearly_parallel = 1'b0;
      for (k = 0; k < 3; k++) begin
         for (i = 0; i < 3; i++) begin
            ax[i][k] = comp_at(w[1 + i], k);
            bx[i][k] = comp_at(w[6 + i], k);
         end
         ha[k] = longint'(w[4][k*obb_pkg::CompWidth +: obb_pkg::CompWidth]);
         hb[k] = longint'(w[9][k*obb_pkg::CompWidth +: obb_pkg::CompWidth]);
         d[k] = comp_at(w[5], k) - comp_at(w[0], k);
      end
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            c[i][j] = ax[i][0] * bx[j][0] + ax[i][1] * bx[j][1] + ax[i][2] * bx[j][2];
            ac[i][j] = (c[i][j] < 0) ? -c[i][j] : c[i][j];
            if (ac[i][j] > (obb_pkg::ParallelLimit <<< obb_pkg::FracBits))
               nearly_parallel = 1'b1;
         end
         t[i] = ax[i][0] * d[0] + ax[i][1] * d[1] + ax[i][2] * d[2];
      end
      // Face axes of box A.
      for (i = 0; i < 3; i++) begin
         lhs = wide_abs(ref_wide_type'(t[i])) <<< obb_pkg::FracBits;
         rhs = ref_wide_type'(ha[i]) <<< (2 * obb_pkg::FracBits);
         for (k = 0; k < 3; k++)
            rhs = rhs + ref_wide_type'(hb[k]) * ref_wide_type'(ac[i][k]);
         if (lhs > rhs) return 1'b0;
      end
      // Face axes of box B.
      for (j = 0; j < 3; j++) begin
         u = bx[j][0] * d[0] + bx[j][1] * d[1] + bx[j][2] * d[2];
         lhs = wide_abs(ref_wide_type'(u)) <<< obb_pkg::FracBits;
         rhs = ref_wide_type'(hb[j]) <<< (2 * obb_pkg::FracBits);
         for (k = 0; k < 3; k++)
            rhs = rhs + ref_wide_type'(ha[k]) * ref_wide_type'(ac[k][j]);
         if (lhs > rhs) return 1'b0;
      end
      if (nearly_parallel) return 1'b1;
      // Edge cross product axes.
      for (i = 0; i < 3; i++) begin
         i1 = (i + 1) % 3;
         i2 = (i + 2) % 3;
         for (j = 0; j < 3; j++) begin
            j1 = (j + 1) % 3;
            j2 = (j + 2) % 3;
            lhs = wide_abs(ref_wide_type'(t[i2]) * ref_wide_type'(c[i1][j])
                           - ref_wide_type'(t[i1]) * ref_wide_type'(c[i2][j]));
            rhs = ref_wide_type'(ha[i1]) * ref_wide_type'(ac[i2][j])
                + ref_wide_type'(ha[i2]) * ref_wide_type'(ac[i1][j])
                + ref_wide_type'(hb[j1]) * ref_wide_type'(ac[i][j2])
                + ref_wide_type'(hb[j2]) * ref_wide_type'(ac[i][j1]);
            if (lhs > (rhs <<< obb_pkg::FracBits)) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [47:0] pack3(input int x, input int y, input int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   // Rotation matrix rows from three random angles, quantized to Q2.14.
   // The rows serve as the three axes of one box.
   task automatic rotated_axes(output logic [47:0] rx, output logic [47:0] ry,
                               output logic [47:0] rz);
      real p, q, r, m[3][3];
      p = $urandom_range(0, 6283) / 1000.0;
      q = $urandom_range(0, 6283) / 1000.0;
      r = $urandom_range(0, 6283) / 1000.0;
      m[0][0] = $cos(q) * $cos(r);
      m[0][1] = $cos(q) * $sin(r);
      m[0][2] = -$sin(q);
      m[1][0] = $sin(p) * $sin(q) * $cos(r) - $cos(p) * $sin(r);
      m[1][1] = $sin(p) * $sin(q) * $sin(r) + $cos(p) * $cos(r);
      m[1][2] = $sin(p) * $cos(q);
      m[2][0] = $cos(p) * $sin(q) * $cos(r) + $sin(p) * $sin(r);
      m[2][1] = $cos(p) * $sin(q) * $sin(r) - $sin(p) * $cos(r);
      m[2][2] = $cos(p) * $cos(q);
      rx = pack3($rtoi(m[0][0] * 16384.0), $rtoi(m[0][1] * 16384.0), $rtoi(m[0][2] * 16384.0));
      ry = pack3($rtoi(m[1][0] * 16384.0), $rtoi(m[1][1] * 16384.0), $rtoi(m[1][2] * 16384.0));
      rz = pack3($rtoi(m[2][0] * 16384.0), $rtoi(m[2][1] * 16384.0), $rtoi(m[2][2] * 16384.0));
   endtask

   task automatic queue_pair(input logic [9:0][47:0] w, input bit drain);
      box_pair_type p;
      p.words = w;
      p.hold_off = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
      p.wait_drain = drain;
      pair_queue.push_back(p);
   endtask

   function automatic int near_coord(input int spread);
      return $urandom_range(0, 2 * spread) - spread;
   endfunction

   // A pair of plausible boxes: rotated unit axes, which box B sometimes shares
   // with box A, and centers close enough that both outcomes are common.
   task automatic queue_plausible_pair(input bit drain);
      logic [9:0][47:0] w;
      int s;
      s = (($urandom_range(0, 3) == 0) ? 4000 : 800);
      w[0] = pack3(near_coord(s), near_coord(s), near_coord(s));
      w[5] = pack3(near_coord(s), near_coord(s), near_coord(s));
      w[4] = pack3($urandom_range(0, 500), $urandom_range(0, 500), $urandom_range(0, 500));
      w[9] = pack3($urandom_range(0, 500), $urandom_range(0, 500), $urandom_range(0, 500));
      rotated_axes(w[1], w[2], w[3]);
      if ($urandom_range(0, 4) == 0) begin
         w[6] = w[1];
         w[7] = w[2];
         w[8] = w[3];
      end else begin
         rotated_axes(w[6], w[7], w[8]);
      end
      queue_pair(w, drain);
   endtask

   task automatic queue_directed_pairs();
      logic [9:0][47:0] w;
      logic [47:0] ex, ey, ez;
      ex = pack3(16384, 0, 0);
      ey = pack3(0, 16384, 0);
      ez = pack3(0, 0, 16384);
      // Degenerate: everything zero.
      queue_pair('0, 1'b0);
      // All ones, and every half length with its top bit set.
      queue_pair({10{48'hFFFF_FFFF_FFFF}}, 1'b0);
      // Most negative components with the largest half lengths.
      w = {10{48'h8000_8000_8000}};
      w[4] = 48'hFFFF_FFFF_FFFF;
      w[9] = 48'hFFFF_FFFF_FFFF;
      queue_pair(w, 1'b0);
      w = {10{48'h7FFF_7FFF_7FFF}};
      w[0] = 48'h8000_8000_8000;
      w[4] = '0;
      w[9] = '0;
      queue_pair(w, 1'b0);
      // Aligned unit boxes: these are nearly parallel, so face tests decide.
      // Touching along x overlaps; one step further apart separates.
      w = '0;
      w[1] = ex; w[2] = ey; w[3] = ez;
      w[6] = ex; w[7] = ey; w[8] = ez;
      w[4] = pack3(16, 16, 16);
      w[9] = pack3(16, 16, 16);
      w[5] = pack3(32, 0, 0);
      queue_pair(w, 1'b0);
      w[5] = pack3(33, 0, 0);
      queue_pair(w, 1'b0);
      w[5] = pack3(0, -33, 0);
      queue_pair(w, 1'b0);
      // Box B turned 45 degrees about z: separated along face axes, then overlapping.
      w[6] = pack3(11585, 11585, 0);
      w[7] = pack3(-11585, 11585, 0);
      w[8] = ez;
      w[5] = pack3(40, 40, 0);
      queue_pair(w, 1'b0);
      w[5] = pack3(20, 20, 0);
      queue_pair(w, 1'b0);
      // Both boxes tilted so that only an edge axis separates them.
      w[1] = pack3(11585, 11585, 0);
      w[2] = pack3(-11585, 11585, 0);
      w[3] = ez;
      w[6] = pack3(11585, 0, 11585);
      w[7] = ey;
      w[8] = pack3(-11585, 0, 11585);
      w[4] = pack3(16, 16, 16);
      w[9] = pack3(16, 16, 16);
      w[5] = pack3(30, -30, 30);
      queue_pair(w, 1'b0);
      w[5] = pack3(25, -25, 25);
      queue_pair(w, 1'b0);
      // Non-unit axes and a zero-sized box.
      w[1] = pack3(32767, -32768, 100);
      w[4] = '0;
      queue_pair(w, 1'b0);
      for (int n = 0; n < 8; n++) queue_plausible_pair(1'b0);
   endtask

   // Driver: presents the next pair at the falling edge once its hold-off
   // has passed, and keeps it steady until the transfer happens.
   always @(negedge clock) begin
      bit next_start;
      next_start = 1'b0;
      if (pair_taken) begin
         pair_taken = 1'b0;
         void'(pair_queue.pop_front());
         stall_count = 0;
      end
      if (!reset && pair_queue.size() > 0) begin
         if (stall_count >= pair_queue[0].hold_off &&
             (!pair_queue[0].wait_drain || overlap_queue.size() == 0)) begin
            next_start = 1'b1;
            drive_words <= pair_queue[0].words;
         end else begin
            stall_count++;
         end
      end
      start <= next_start;
   end

   // Monitor: records each transfer with its predicted outcome, checks each
   // result against the oldest prediction and watches for a hung pipeline.
   always @(posedge clock) begin
      bit expected;
      if (!reset) begin
         idle_cycles++;
         if (start && !busy) begin
            overlap_queue.push_back(boxes_touch(drive_words));
            pair_taken = 1'b1;
            idle_cycles = 0;
         end
         if (rsp_valid) begin
            idle_cycles = 0;
            if (overlap_queue.size() == 0) begin
               $error("unexpected result transfer, overlap %0b", rsp_overlap);
               failures++;
            end else begin
               expected = overlap_queue.pop_front();
               if (rsp_overlap !== expected) begin
                  $error("overlap: expected %0b, actual %0b", expected, rsp_overlap);
                  failures++;
               end
            end
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      queue_directed_pairs();
      for (int n = 0; n < RandomPairs; n++) begin
         // Most pairs are plausible boxes; the rest are raw bit patterns.
         // Every few hundred pairs the sender waits for the pipeline to drain.
         if (n % 300 == 150 || $urandom_range(0, 9) < 7) begin
            queue_plausible_pair(n % 300 == 150);
         end else begin
            logic [9:0][47:0] w;
            for (int f = 0; f < 10; f++) w[f] = 48'({$urandom(), $urandom()});
            queue_pair(w, 1'b0);
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // Wait until every pair has been transferred and every result seen,
      // then keep watching for any stray result before the verdict.
      while (pair_queue.size() > 0 || start || overlap_queue.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0 && overlap_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
